>>> rtl/qvr_pkg.sv
package qvr_pkg;

   localparam int VecWidth   = 32;
   localparam int QuatWidth  = 16;
   localparam int NumComp    = 3;
   // sum of four squares, unsigned
   localparam int NormWidth  = 2 * QuatWidth + 1;
   // matrix entries are bounded by the norm in magnitude
   localparam int MatWidth   = 2 * QuatWidth + 2;
   localparam int ProdWidth  = MatWidth + VecWidth;
   localparam int SumWidth   = ProdWidth + 2;
   // |R*v| / n stays below 2^(VecWidth+1)
   localparam int QuotWidth  = VecWidth + 2;

   localparam logic signed [QuatWidth-1:0] QuatWReset = QuatWidth'(1 << (QuatWidth - 2));

   typedef enum logic [1:0] {
      CSR_QUAT_X = 2'd0,
      CSR_QUAT_Y = 2'd1,
      CSR_QUAT_Z = 2'd2,
      CSR_QUAT_W = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [VecWidth-1:0] in_x;
      logic signed [VecWidth-1:0] in_y;
      logic signed [VecWidth-1:0] in_z;
   } req_type;

   typedef struct packed {
      logic signed [VecWidth-1:0] out_x;
      logic signed [VecWidth-1:0] out_y;
      logic signed [VecWidth-1:0] out_z;
      logic                       saturated;
      logic                       degenerate;
   } rsp_type;

endpackage

>>> rtl/qvr_coef.sv
module qvr_coef import qvr_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  csr_index_type               csr_index,
   input  logic [QuatWidth-1:0]        csr_wdata,
   output logic signed [MatWidth-1:0]  mat [NumComp*NumComp],
   output logic [NormWidth-1:0]        norm
);

   logic signed [QuatWidth-1:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic signed [QuatWidth-1:0] qx_in, qy_in, qz_in, qw_in;

   logic signed [2*QuatWidth-1:0] ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [2*QuatWidth-1:0] xy_ff, wz_ff, xz_ff, wy_ff, yz_ff, wx_ff;

   logic signed [MatWidth-1:0] mat_ff [NumComp*NumComp];
   logic signed [MatWidth-1:0] mat_in [NumComp*NumComp];
   logic [NormWidth-1:0]       norm_ff, norm_in;

   always_comb begin
      qx_in = qx_ff;
      qy_in = qy_ff;
      qz_in = qz_ff;
      qw_in = qw_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_QUAT_X: qx_in = csr_wdata;
            CSR_QUAT_Y: qy_in = csr_wdata;
            CSR_QUAT_Z: qz_in = csr_wdata;
            CSR_QUAT_W: qw_in = csr_wdata;
            default:    qx_in = qx_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qx_ff <= '0;
         qy_ff <= '0;
         qz_ff <= '0;
         qw_ff <= QuatWReset;
      end else begin
         qx_ff <= qx_in;
         qy_ff <= qy_in;
         qz_ff <= qz_in;
         qw_ff <= qw_in;
      end
   end

   // products of the quaternion terms
   always_ff @(posedge clock) begin
      ww_ff <= qw_ff * qw_ff;
      xx_ff <= qx_ff * qx_ff;
      yy_ff <= qy_ff * qy_ff;
      zz_ff <= qz_ff * qz_ff;
      xy_ff <= qx_ff * qy_ff;
      wz_ff <= qw_ff * qz_ff;
      xz_ff <= qx_ff * qz_ff;
      wy_ff <= qw_ff * qy_ff;
      yz_ff <= qy_ff * qz_ff;
      wx_ff <= qw_ff * qx_ff;
   end

   always_comb begin
      mat_in[0] = MatWidth'(ww_ff) + MatWidth'(xx_ff) - MatWidth'(yy_ff) - MatWidth'(zz_ff);
      mat_in[1] = (MatWidth'(xy_ff) - MatWidth'(wz_ff)) <<< 1;
      mat_in[2] = (MatWidth'(xz_ff) + MatWidth'(wy_ff)) <<< 1;
      mat_in[3] = (MatWidth'(xy_ff) + MatWidth'(wz_ff)) <<< 1;
      mat_in[4] = MatWidth'(ww_ff) - MatWidth'(xx_ff) + MatWidth'(yy_ff) - MatWidth'(zz_ff);
      mat_in[5] = (MatWidth'(yz_ff) - MatWidth'(wx_ff)) <<< 1;
      mat_in[6] = (MatWidth'(xz_ff) - MatWidth'(wy_ff)) <<< 1;
      mat_in[7] = (MatWidth'(yz_ff) + MatWidth'(wx_ff)) <<< 1;
      mat_in[8] = MatWidth'(ww_ff) - MatWidth'(xx_ff) - MatWidth'(yy_ff) + MatWidth'(zz_ff);
      norm_in   = NormWidth'(ww_ff) + NormWidth'(xx_ff) + NormWidth'(yy_ff)
                + NormWidth'(zz_ff);
   end

   always_ff @(posedge clock) begin
      mat_ff  <= mat_in;
      norm_ff <= norm_in;
   end

   assign mat  = mat_ff;
   assign norm = norm_ff;

endmodule

>>> rtl/qvr_divstep.sv
module qvr_divstep import qvr_pkg::*; (
   input  logic                 clock,
   input  logic [NormWidth-1:0] norm,
   input  logic [NormWidth-1:0] rem_i,
   input  logic [QuotWidth-1:0] lq_i,
   output logic [NormWidth-1:0] rem_o,
   output logic [QuotWidth-1:0] lq_o
);

   // lq holds the dividend bits still to come at the top, quotient bits enter at the bottom
   logic [NormWidth:0]   trial;
   logic                 fits;
   logic [NormWidth-1:0] rem_ff, rem_in;
   logic [QuotWidth-1:0] lq_ff, lq_in;

   always_comb begin
      trial  = {rem_i, lq_i[QuotWidth-1]};
      fits   = trial >= {1'b0, norm};
      rem_in = fits ? NormWidth'(trial - {1'b0, norm}) : NormWidth'(trial);
      lq_in  = {lq_i[QuotWidth-2:0], fits};
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      lq_ff  <= lq_in;
   end

   assign rem_o = rem_ff;
   assign lq_o  = lq_ff;

endmodule

>>> rtl/quaternion_vector_rotate_core.sv
// channel   ports                               direction  notes
// request   start, busy, req_data               in         item taken when start & !busy
// response  rsp_valid, rsp_data                 out        one-cycle strobe, no back-pressure
// config    csr_we, csr_index, csr_wdata        in         write only, taken on csr_we
//
// one item per cycle; most of the pipeline is the restoring divider,
// one quotient bit per stage for each component
// busy stays low: the pipeline never stalls since the receiver cannot push back
// reset clears the quaternion to identity and drops all in-flight valid bits
// the rotation matrix and norm follow the quaternion registers through the product and matrix registers
module quaternion_vector_rotate_core import qvr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  csr_index_type        csr_index,
   input  logic [QuatWidth-1:0] csr_wdata
);

   localparam int NumStages = QuotWidth + 5;

   logic signed [MatWidth-1:0] mat [NumComp*NumComp];
   logic [NormWidth-1:0]       norm;

   qvr_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mat       (mat),
      .norm      (norm)
   );

   assign busy = 1'b0;

   // valid bits travel alongside the data
   logic [NumStages-1:0] vld_ff, vld_in;
   logic                 rsp_valid_ff;

   always_comb begin
      vld_in = {vld_ff[NumStages-2:0], start};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[NumStages-1];
      end
   end

   // two input stages give the matrix time to settle after a config write
   logic signed [VecWidth-1:0] v1_ff [NumComp];
   logic signed [VecWidth-1:0] v2_ff [NumComp];

   always_ff @(posedge clock) begin
      v1_ff[0] <= req_data.in_x;
      v1_ff[1] <= req_data.in_y;
      v1_ff[2] <= req_data.in_z;
      v2_ff    <= v1_ff;
   end

   // matrix times vector: nine products, then row sums
   logic signed [ProdWidth-1:0] prod_ff [NumComp*NumComp];
   logic signed [SumWidth-1:0]  sum_ff  [NumComp];

   always_ff @(posedge clock) begin
      for (int i = 0; i < NumComp * NumComp; i++) begin
         prod_ff[i] <= ProdWidth'(mat[i]) * ProdWidth'(v2_ff[i % NumComp]);
      end
      for (int i = 0; i < NumComp; i++) begin
         sum_ff[i] <= SumWidth'(prod_ff[NumComp*i]) + SumWidth'(prod_ff[NumComp*i+1])
                    + SumWidth'(prod_ff[NumComp*i+2]);
      end
   end

   // sign and magnitude, split into the first partial remainder and the bits to shift in
   logic [NormWidth-1:0] rem_chain [NumComp][QuotWidth+1];
   logic [QuotWidth-1:0] lq_chain  [NumComp][QuotWidth+1];
   logic [QuotWidth:0]   neg_ff    [NumComp];
   logic [SumWidth-1:0]  mag       [NumComp];

   always_comb begin
      for (int c = 0; c < NumComp; c++) begin
         mag[c] = sum_ff[c][SumWidth-1] ? SumWidth'(-sum_ff[c]) : SumWidth'(sum_ff[c]);
      end
   end

   for (genvar c = 0; c < NumComp; c++) begin : g_comp
      logic [NormWidth-1:0] rem0_ff;
      logic [QuotWidth-1:0] lq0_ff;

      always_ff @(posedge clock) begin
         // magnitude is below norm * 2^QuotWidth, so the top part fits the remainder
         rem0_ff   <= NormWidth'(mag[c] >> QuotWidth);
         lq0_ff    <= mag[c][QuotWidth-1:0];
         neg_ff[c] <= {neg_ff[c][QuotWidth-1:0], sum_ff[c][SumWidth-1]};
      end

      assign rem_chain[c][0] = rem0_ff;
      assign lq_chain[c][0]  = lq0_ff;

      for (genvar s = 0; s < QuotWidth; s++) begin : g_step
         qvr_divstep u_step (
            .clock (clock),
            .norm  (norm),
            .rem_i (rem_chain[c][s]),
            .lq_i  (lq_chain[c][s]),
            .rem_o (rem_chain[c][s+1]),
            .lq_o  (lq_chain[c][s+1])
         );
      end
   end

   // round half away from zero, clamp, restore sign; a zero norm gives a zero result flagged degenerate
   logic [NormWidth:0]         twice_rem [NumComp];
   logic [QuotWidth:0]         rounded   [NumComp];
   logic [QuotWidth:0]         limit     [NumComp];
   logic [QuotWidth:0]         clamped   [NumComp];
   logic                       clip      [NumComp];
   logic signed [VecWidth-1:0] res       [NumComp];
   logic                       degen;
   rsp_type                    rsp_ff, rsp_in;

   always_comb begin
      degen = norm == '0;
      for (int c = 0; c < NumComp; c++) begin
         twice_rem[c] = {rem_chain[c][QuotWidth], 1'b0};
         rounded[c]   = (QuotWidth+1)'(lq_chain[c][QuotWidth])
                      + (QuotWidth+1)'(twice_rem[c] >= {1'b0, norm});
         limit[c]     = neg_ff[c][QuotWidth] ? (QuotWidth+1)'(1) << (VecWidth - 1)
                                             : ((QuotWidth+1)'(1) << (VecWidth - 1)) - 1'b1;
         clip[c]      = rounded[c] > limit[c];
         clamped[c]   = clip[c] ? limit[c] : rounded[c];
         res[c]       = neg_ff[c][QuotWidth] ? -clamped[c][VecWidth-1:0]
                                             : clamped[c][VecWidth-1:0];
      end
      rsp_in.out_x      = degen ? '0 : res[0];
      rsp_in.out_y      = degen ? '0 : res[1];
      rsp_in.out_z      = degen ? '0 : res[2];
      rsp_in.saturated  = !degen && (clip[0] || clip[1] || clip[2]);
      rsp_in.degenerate = degen;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
